[rtl/fow_pkg.sv]
package fow_pkg;

  // signed width for box bounds, counters and sizes (covers -15 .. 1023+15)
  localparam int CW = 12;

  // tile codes
  localparam logic [1:0] CODE_UNKNOWN = 2'd0;
  localparam logic [1:0] CODE_KNOWN   = 2'd1;
  localparam logic [1:0] CODE_VISIBLE = 2'd2;

  // register indexes on the config port
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_START_X    = 2'd2;
  localparam logic [1:0] REG_START_Y    = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_QREAD,
    ST_QOUT
  } state_t;

endpackage

[rtl/fog_of_war_tile_map.sv]
// Channel  | Handshake                   | Word
// ---------+-----------------------------+------------------------------
// in       | in_valid / in_ready         | cmd, x_coord, y_coord
// out      | out_valid / out_ready       | visibility, in_range
// apb      | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A visit holds in_ready low after its accept through a setup state, then
// a walk of one tile a cycle over the T tiles in the clipped box (30 for
// a one-tile step along an axis, 36 for a diagonal one). The tile memory does
// one read-modify-write per cycle, a read at one tile overlapping the write
// of the one before. A query holds in_ready low through the memory read
// and the output load, and for as long as a waiting result stalls the load.
// After reset a clearing pass writes every tile to unknown, one per cycle,
// during which in_ready is low.
// A result waiting on out_ready holds a finished query back; visits go on.
module fog_of_war_tile_map #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int WINDOW     = 5
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [5:0]  x_coord,
  input  logic [5:0]  y_coord,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  visibility,
  output logic        in_range,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fow_pkg::*;

  localparam int HALF  = WINDOW / 2;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // tile address at row stride MAX_WIDTH
  function automatic logic [AW-1:0] tile_idx(input logic [CW-1:0] c,
                                             input logic [CW-1:0] r);
    return AW'(AW'(r) * AW'(MAX_WIDTH) + AW'(c));
  endfunction

  state_t state, state_next;

  // config and viewer
  logic [6:0] map_width, map_height;
  logic [5:0] start_x, start_y;
  logic [5:0] viewer_x, viewer_y;
  logic       cfg_wr;
  logic signed [CW-1:0] eff_w, eff_h;

  // accepted item
  logic [5:0] item_x, item_y;

  // walk state
  logic signed [CW-1:0] col, row, col_lo, col_hi, row_hi;
  logic signed [CW-1:0] win_x_lo, win_x_hi, win_y_lo, win_y_hi;
  logic signed [CW-1:0] lo_x, hi_x, wlo_x, whi_x;
  logic signed [CW-1:0] lo_y, hi_y, wlo_y, whi_y;
  logic                 box_empty, walk_last, in_win;

  // memory ports
  logic [1:0]    tile_mem [DEPTH];
  logic          rd_en, we;
  logic [AW-1:0] rd_addr, wa, clr_cnt;
  logic [1:0]    rd_data, wd;
  logic          wr_pend, wr_vis;
  logic [AW-1:0] wr_addr;

  // query
  logic q_hit, q_fits, out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // saturate sizes to the map store
  assign eff_w = (map_width > MAX_WIDTH) ? CW'(MAX_WIDTH) : signed'(CW'(map_width));
  assign eff_h = (map_height > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : signed'(CW'(map_height));
  assign q_fits = (signed'(CW'(item_x)) < eff_w) && (signed'(CW'(item_y)) < eff_h);

  // box bounds per axis
  fow_axis_clip #(.HALF(HALF)) u_clip_x (
    .new_pos(item_x), .old_pos(viewer_x), .size(eff_w),
    .lo(lo_x), .hi(hi_x), .win_lo(wlo_x), .win_hi(whi_x)
  );
  fow_axis_clip #(.HALF(HALF)) u_clip_y (
    .new_pos(item_y), .old_pos(viewer_y), .size(eff_h),
    .lo(lo_y), .hi(hi_y), .win_lo(wlo_y), .win_hi(whi_y)
  );

  assign box_empty = (lo_x > hi_x) || (lo_y > hi_y);
  assign walk_last = (col == col_hi) && (row == row_hi);
  assign in_win    = (col >= win_x_lo) && (col <= win_x_hi) &&
                     (row >= win_y_lo) && (row <= win_y_hi);

  // config readback
  always_comb begin
    unique case (paddr[3:2])
      REG_MAP_WIDTH:  prdata = {25'd0, map_width};
      REG_MAP_HEIGHT: prdata = {25'd0, map_height};
      REG_START_X:    prdata = {26'd0, start_x};
      REG_START_Y:    prdata = {26'd0, start_y};
      default:        prdata = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory read control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = tile_idx(col, row);
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = cmd ? ST_QREAD : ST_SETUP;
      end
      ST_SETUP: begin
        state_next = box_empty ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (walk_last) state_next = ST_IDLE;
      end
      ST_QREAD: begin
        rd_en      = q_fits;
        rd_addr    = tile_idx(CW'(item_x), CW'(item_y));
        state_next = ST_QOUT;
      end
      ST_QOUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // write port: clearing pass or the pending walk write
  always_comb begin
    we = (state == ST_CLEAR) || wr_pend;
    wa = (state == ST_CLEAR) ? clr_cnt : wr_addr;
    if (state == ST_CLEAR) begin
      wd = CODE_UNKNOWN;
    end else if (wr_vis) begin
      wd = CODE_VISIBLE;
    end else if (rd_data != CODE_UNKNOWN) begin
      wd = CODE_KNOWN;
    end else begin
      wd = CODE_UNKNOWN;
    end
  end

  // tile memory
  always_ff @(posedge clk) begin
    if (we) tile_mem[wa] <= wd;
    if (rd_en) rd_data <= tile_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      wr_pend    <= 1'b0;
      out_valid  <= 1'b0;
      map_width  <= 7'd64;
      map_height <= 7'd64;
      start_x    <= '0;
      start_y    <= '0;
      viewer_x   <= '0;
      viewer_y   <= '0;
    end else begin
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      wr_pend <= (state == ST_WALK);
      if (state == ST_QOUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // viewer moves once the box is latched
      if (state == ST_SETUP) begin
        viewer_x <= item_x;
        viewer_y <= item_y;
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_MAP_WIDTH:  map_width  <= pwdata[6:0];
          REG_MAP_HEIGHT: map_height <= pwdata[6:0];
          REG_START_X: begin
            start_x  <= pwdata[5:0];
            viewer_x <= pwdata[5:0];
          end
          REG_START_Y: begin
            start_y  <= pwdata[5:0];
            viewer_y <= pwdata[5:0];
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_x <= x_coord;
      item_y <= y_coord;
    end
    if (state == ST_SETUP) begin
      col      <= lo_x;
      row      <= lo_y;
      col_lo   <= lo_x;
      col_hi   <= hi_x;
      row_hi   <= hi_y;
      win_x_lo <= wlo_x;
      win_x_hi <= whi_x;
      win_y_lo <= wlo_y;
      win_y_hi <= whi_y;
    end
    // row-major walk, one tile a cycle
    if (state == ST_WALK) begin
      wr_addr <= rd_addr;
      wr_vis  <= in_win;
      if (col == col_hi) begin
        col <= col_lo;
        row <= row + CW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
    if (state == ST_QREAD) q_hit <= q_fits;
    if (state == ST_QOUT && out_free) begin
      visibility <= q_hit ? rd_data : CODE_UNKNOWN;
      in_range   <= q_hit;
    end
  end

endmodule

[rtl/fow_axis_clip.sv]
// One axis of a visit: span of old and new windows clipped to the map,
// plus the new window edges.
module fow_axis_clip #(
  parameter int HALF = 2
) (
  input  logic [5:0]                   new_pos,
  input  logic [5:0]                   old_pos,
  input  logic signed [fow_pkg::CW-1:0] size,
  output logic signed [fow_pkg::CW-1:0] lo,
  output logic signed [fow_pkg::CW-1:0] hi,
  output logic signed [fow_pkg::CW-1:0] win_lo,
  output logic signed [fow_pkg::CW-1:0] win_hi
);
  import fow_pkg::*;

  localparam logic signed [CW-1:0] HALF_S = CW'(HALF);
  localparam logic signed [CW-1:0] ONE_S  = CW'(1);

  logic signed [CW-1:0] nv;
  logic signed [CW-1:0] ov;
  logic signed [CW-1:0] mn;
  logic signed [CW-1:0] mx;
  logic signed [CW-1:0] lo_raw;
  logic signed [CW-1:0] hi_raw;
  logic signed [CW-1:0] last;

  assign nv = signed'(CW'(new_pos));
  assign ov = signed'(CW'(old_pos));

  // span of both windows
  assign mn     = (nv < ov) ? nv : ov;
  assign mx     = (nv > ov) ? nv : ov;
  assign lo_raw = mn - HALF_S;
  assign hi_raw = mx + HALF_S;
  assign last   = size - ONE_S;

  // clip to the map; an empty map leaves hi below lo
  assign lo = (lo_raw < 0) ? '0 : lo_raw;
  assign hi = (hi_raw > last) ? last : hi_raw;

  assign win_lo = nv - HALF_S;
  assign win_hi = nv + HALF_S;

endmodule

[rtl/fow_checker.sv]
module fow_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] visibility,
  input logic       in_range
);
  import fow_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visibility) && $stable(in_range))
    else $error("result word changed while stalled");

  // out-of-map query reads as unknown
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> visibility == CODE_UNKNOWN)
    else $error("out-of-range query with nonzero code");

  // no code beyond visible
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> visibility <= CODE_VISIBLE)
    else $error("illegal tile code");

  // every accepted word makes the block busy, so no two words are accepted back to back
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted back to back");

  // clearing pass follows reset
  a_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready right after reset");

endmodule

bind fog_of_war_tile_map fow_checker u_fow_checker (.*);

[sim/fog_of_war_tile_map_tb.sv]
module fog_of_war_tile_map_tb;
  import fow_pkg::*;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int WIN   = 5;
  localparam int HALF  = WIN / 2;

  // item opcodes
  localparam logic CMD_VISIT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // a full-map walk or the clearing pass after reset, plus margin
  localparam int SETTLE_CYCLES = MAX_W * MAX_H + 64;
  localparam int TAIL_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 50000;

  typedef struct packed {
    logic [1:0] vis;
    logic       hit;
  } tile_answer_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_VISIT;
  logic [5:0]  x_coord = '0;
  logic [5:0]  y_coord = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  visibility;
  logic        in_range;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted block state
  logic [1:0]  fog_map [MAX_W*MAX_H];
  logic [6:0]  map_cols_reg;
  logic [6:0]  map_rows_reg;
  logic [5:0]  home_x_reg;
  logic [5:0]  home_y_reg;
  int          view_x;
  int          view_y;

  tile_answer_t pending_answers[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           quiet_cycles = 0;

  fog_of_war_tile_map #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .WINDOW    (WIN)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visibility(visibility),
    .in_range  (in_range),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------

  // sizes above the maximum saturate
  function automatic int map_cols();
    return (map_cols_reg > MAX_W) ? MAX_W : int'(map_cols_reg);
  endfunction

  function automatic int map_rows();
    return (map_rows_reg > MAX_H) ? MAX_H : int'(map_rows_reg);
  endfunction

  function automatic void clear_fog_model();
    foreach (fog_map[k]) fog_map[k] = CODE_UNKNOWN;
    map_cols_reg = 7'd64;
    map_rows_reg = 7'd64;
    home_x_reg   = '0;
    home_y_reg   = '0;
    view_x       = 0;
    view_y       = 0;
  endfunction

  // walk the box over old and new windows, clipped to the map
  function automatic void apply_visit(int nx, int ny);
    int x0, y0, x1, y1;
    int idx;
    x0 = ((nx < view_x) ? nx : view_x) - HALF;
    y0 = ((ny < view_y) ? ny : view_y) - HALF;
    x1 = ((nx > view_x) ? nx : view_x) + HALF;
    y1 = ((ny > view_y) ? ny : view_y) + HALF;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > map_cols() - 1) x1 = map_cols() - 1;
    if (y1 > map_rows() - 1) y1 = map_rows() - 1;
    for (int i = x0; i <= x1; i++) begin
      for (int j = y0; j <= y1; j++) begin
        idx = j * MAX_W + i;
        if (i >= nx - HALF && i <= nx + HALF && j >= ny - HALF && j <= ny + HALF)
          fog_map[idx] = CODE_VISIBLE;
        else if (fog_map[idx] != CODE_UNKNOWN)
          fog_map[idx] = CODE_KNOWN;
      end
    end
    view_x = nx;
    view_y = ny;
  endfunction

  function automatic tile_answer_t predict_query(int qx, int qy);
    tile_answer_t ans;
    if (qx < map_cols() && qy < map_rows()) begin
      ans.vis = fog_map[qy * MAX_W + qx];
      ans.hit = 1'b1;
    end else begin
      ans.vis = CODE_UNKNOWN;
      ans.hit = 1'b0;
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------

  // one word on the item channel; predicts at the accepting edge
  task automatic send_word(logic op, logic [5:0] x, logic [5:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    x_coord  <= x;
    y_coord  <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == CMD_QUERY)
      pending_answers.push_back(predict_query(int'(x), int'(y)));
    else
      apply_visit(int'(x), int'(y));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAP_WIDTH:  map_cols_reg = value[6:0];
      REG_MAP_HEIGHT: map_rows_reg = value[6:0];
      REG_START_X: begin
        home_x_reg = value[5:0];
        view_x     = int'(value[5:0]);
      end
      REG_START_Y: begin
        home_y_reg = value[5:0];
        view_y     = int'(value[5:0]);
      end
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // results drained, then room for a visit walk that yields nothing
  task automatic wait_block_idle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [31:0] cols, logic [31:0] rows,
                               logic [31:0] sx, logic [31:0] sy);
    wait_block_idle();
    write_reg(REG_MAP_WIDTH, cols);
    write_reg(REG_MAP_HEIGHT, rows);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
  endtask

  // ---------------------------------------------------------------
  // Result side: random stall and in-order check
  // ---------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    tile_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result vis=%0d in_range=%0d with nothing pending",
                                  visibility, in_range));
      end else begin
        want = pending_answers.pop_front();
        if (visibility !== want.vis)
          report_mismatch($sformatf("visibility got %0d want %0d", visibility, want.vis));
        if (in_range !== want.hit)
          report_mismatch($sformatf("in_range got %0d want %0d", in_range, want.hit));
      end
    end
  end

  // watchdog: cycles with no word moving on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fog_of_war_tile_map_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // fresh map after the clearing pass
  task automatic test_cold_map();
    send_word(CMD_QUERY, 6'd0, 6'd0);
    send_word(CMD_QUERY, 6'd63, 6'd63);
    send_word(CMD_QUERY, 6'd63, 6'd0);
  endtask

  // window at both corners, a full-map walk between them, a visit in place
  task automatic test_corner_visits();
    send_word(CMD_VISIT, 6'd0, 6'd0);
    send_word(CMD_QUERY, 6'd2, 6'd2);
    send_word(CMD_QUERY, 6'd3, 6'd3);
    send_word(CMD_VISIT, 6'd63, 6'd63);
    send_word(CMD_QUERY, 6'd0, 6'd0);
    send_word(CMD_QUERY, 6'd62, 6'd61);
    send_word(CMD_VISIT, 6'd63, 6'd63);
    send_word(CMD_QUERY, 6'd63, 6'd63);
  endtask

  // shrunk map: queries past the edge, a visit whose box lies outside
  task automatic test_clipped_map();
    wait_block_idle();
    write_reg(REG_MAP_WIDTH, 32'd10);
    write_reg(REG_MAP_HEIGHT, 32'd20);
    send_word(CMD_QUERY, 6'd10, 6'd5);
    send_word(CMD_QUERY, 6'd9, 6'd19);
    send_word(CMD_QUERY, 6'd9, 6'd20);
    send_word(CMD_VISIT, 6'd62, 6'd62);
    send_word(CMD_VISIT, 6'd8, 6'd18);
    send_word(CMD_QUERY, 6'd8, 6'd18);
  endtask

  // sizes above the maximum, upper data bits set
  task automatic test_size_saturation();
    wait_block_idle();
    write_reg(REG_MAP_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_MAP_HEIGHT, 32'd65);
    send_word(CMD_QUERY, 6'd63, 6'd63);
    send_word(CMD_QUERY, 6'd62, 6'd0);
  endtask

  // zero columns: no tile changes, viewer still moves, tiles kept after
  task automatic test_empty_map();
    wait_block_idle();
    write_reg(REG_MAP_WIDTH, 32'h0000_0080);
    send_word(CMD_QUERY, 6'd0, 6'd0);
    send_word(CMD_VISIT, 6'd5, 6'd5);
    wait_block_idle();
    write_reg(REG_MAP_WIDTH, 32'd64);
    write_reg(REG_MAP_HEIGHT, 32'd64);
    send_word(CMD_QUERY, 6'd5, 6'd5);
  endtask

  // start position written as a viewer preset
  task automatic test_viewer_preset();
    wait_block_idle();
    write_reg(REG_START_X, 32'd40);
    write_reg(REG_START_Y, 32'd63);
    send_word(CMD_VISIT, 6'd41, 6'd62);
    send_word(CMD_QUERY, 6'd38, 6'd61);
    send_word(CMD_QUERY, 6'd40, 6'd63);
  endtask

  // mostly short moves and nearby queries, with jumps and stray queries
  task automatic test_random_walk(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35)
        send_word(CMD_VISIT, 6'(view_x + $urandom_range(4) + 62),
                  6'(view_y + $urandom_range(4) + 62));
      else if (roll < 70)
        send_word(CMD_QUERY, 6'(view_x + $urandom_range(8) + 60),
                  6'(view_y + $urandom_range(8) + 60));
      else if (roll < 78)
        send_word(CMD_VISIT, 6'($urandom_range(63)), 6'($urandom_range(63)));
      else
        send_word(CMD_QUERY, 6'($urandom_range(63)), 6'($urandom_range(63)));
    end
  endtask

  initial begin
    clear_fog_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cold_map();
    test_corner_visits();
    test_clipped_map();
    test_size_saturation();
    test_empty_map();
    test_viewer_preset();

    // sender idles lightly, receiver heavily
    send_idle_pct = 17;
    sink_idle_pct = 61;
    load_settings(32'd64, 32'd64, $urandom_range(63), $urandom_range(63));
    test_random_walk(175);
    load_settings($urandom_range(64, 1), $urandom_range(64, 1),
                  $urandom_range(63), $urandom_range(63));
    test_random_walk(175);

    // the other way round
    send_idle_pct = 61;
    sink_idle_pct = 17;
    load_settings(32'd127, 32'd65, $urandom_range(63), $urandom_range(63));
    test_random_walk(175);
    load_settings(32'd1, 32'd64, 32'd0, $urandom_range(63));
    test_random_walk(175);

    // no idling at all
    send_idle_pct = 0;
    sink_idle_pct = 0;
    load_settings(32'd64, 32'd1, $urandom_range(63), 32'd0);
    test_random_walk(175);
    load_settings($urandom_range(64, 1), $urandom_range(64, 1),
                  $urandom_range(63), $urandom_range(63));
    test_random_walk(175);

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("fog_of_war_tile_map_tb: PASS");
    else
      $display("fog_of_war_tile_map_tb: FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/fow_pkg.sv
rtl/fow_axis_clip.sv
rtl/fog_of_war_tile_map.sv
rtl/fow_checker.sv
sim/fog_of_war_tile_map_tb.sv
